FILE: rtl/hufftbp_pkg.sv
// Shared types, codes and helper functions for the Huffman table builder and bit packer.
`timescale 1ns / 1ps

package hufftbp_pkg;

   // Table geometry and code length limit
   localparam int SYMBOLS      = 256;
   localparam int SYM_W        = $clog2(SYMBOLS);
   localparam int MAX_CODE_LEN = 16;
   localparam int LEN_CAP      = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
   localparam int CODE_W       = 16;
   localparam int LEN_W        = 5;
   localparam int COUNT_W      = 24;

   // Request kinds carried on the input tuser
   localparam logic [1:0] REQ_MERGE = 2'd0;
   localparam logic [1:0] REQ_PIXEL = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;

   // One code table entry: length and right-aligned code bits
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } entry_type;

   // Result of appending one bit to a code
   typedef struct packed {
      entry_type entry;
      logic      ovf;
   } append_type;

   // One output beat waiting in the result queue
   typedef struct packed {
      logic [7:0]         data_byte;
      logic               last;
      logic [COUNT_W-1:0] count;
      logic               ovf;
   } beat_type;

   // Append a bit to a code; a code already at the cap keeps its value and flags overflow.
   function automatic append_type append_bit(input entry_type e, input logic b);
      append_type r;
      r.entry = e;
      r.ovf   = 1'b0;
      if (e.len >= LEN_W'(LEN_CAP)) begin
         r.ovf = 1'b1;
      end else begin
         r.entry.bits = {e.bits[CODE_W-2:0], b};
         r.entry.len  = e.len + LEN_W'(1);
      end
      return r;
   endfunction

   // Saturating increment of the byte counter
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      r = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
      return r;
   endfunction

endpackage

FILE: rtl/huffman_table_build_and_pack_top.sv
// Huffman code table builder with an MSB-first bit packer and a two-beat result queue.
`timescale 1ns / 1ps

// Channel  | Direction | Beat contents
// ---------+-----------+-----------------------------------------------------------
// req_     | in        | tuser: req_type; tdata: merge_first, merge_second, pixel_value
// rsp_     | out       | tlast: is_last; tdata: out_byte, byte_count, code_overflow
//
// A merge beat goes through a table read, a write of the fresh entry and a write of the
// partner; a pixel or flush beat goes through a table read and a pack into the queue.
// The code table is a synchronous RAM with two read ports and one write port; the
// per-entry valid flops are cleared at reset, so no clearing pass is needed.
// A pixel or flush waits in its pack step until the result queue has room for its
// bytes, with its table read data held; merges go on while earlier bytes are still
// waiting on rsp_tready.

module huffman_table_build_and_pack_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] merge_first, [15:8] merge_second, [23:16] pixel_value
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [31:8] byte_count, [32] code_overflow
   output logic        rsp_tlast    // is_last
);

   import hufftbp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WR2  = 2'd2;

   // Control state
   logic [1:0]         state_ff, state_in;
   logic [6:0]         acc_ff, acc_in;
   logic [2:0]         pend_ff, pend_in;
   logic [COUNT_W-1:0] emitted_ff, emitted_in;
   logic               ovf_ff, ovf_in;
   logic [SYMBOLS-1:0] entry_valid_ff;

   // Captured item
   logic [1:0]        kind_ff;
   logic [SYM_W-1:0]  first_ff, second_ff;

   // Code table and its read data
   entry_type         code_mem [SYMBOLS];
   entry_type         rd_a_ff, rd_b_ff;
   logic              va_ff, vb_ff;
   logic [SYM_W-1:0]  addr_a, addr_b;

   // Write port
   logic              wr_en;
   logic [SYM_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic [SYM_W-1:0]  partner_ff, partner_in;
   entry_type         pnew_ff, pnew_in;

   // Result queue
   beat_type          q_mem_ff [2];
   logic              q_wr_ff, q_rd_ff;
   logic [1:0]        q_cnt_ff;
   logic [1:0]        push_n;
   beat_type          push0, push1;
   logic              pop;

   // Merge and pack datapath
   entry_type         a_val, b_val, pval;
   append_type        fresh_app, part_app;
   logic [SYM_W-1:0]  fresh_idx, part_idx;
   logic [22:0]       total;
   logic [15:0]       code_mask;
   logic [4:0]        nbits;
   logic [4:0]        len_c;
   logic [22:0]       sh1, sh2;
   logic [1:0]        need;
   logic              room;
   logic [COUNT_W-1:0] cnt1, cnt2;

   assign req_tready = (state_ff == ST_IDLE);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign rsp_tdata  = {7'd0, q_mem_ff[q_rd_ff].ovf, q_mem_ff[q_rd_ff].count,
                        q_mem_ff[q_rd_ff].data_byte};
   assign rsp_tlast  = q_mem_ff[q_rd_ff].last;

   // Read addresses come straight from the input beat; data is used in the next cycle.
   assign addr_a = (req_tuser == REQ_PIXEL) ? req_tdata[23:16] : req_tdata[7:0];
   assign addr_b = req_tdata[15:8];

   // Synchronous code table RAM; read data stays put while an item is in progress.
   always_ff @(posedge clock) begin
      if (req_tready) begin
         rd_a_ff <= code_mem[addr_a];
         rd_b_ff <= code_mem[addr_b];
      end
      if (wr_en) begin
         code_mem[wr_addr] <= wr_data;
      end
   end

   // Valid flops stand in for clearing the table at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         va_ff          <= 1'b0;
         vb_ff          <= 1'b0;
      end else begin
         if (req_tready) begin
            va_ff <= entry_valid_ff[addr_a];
            vb_ff <= entry_valid_ff[addr_b];
         end
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Merge: pick fresh entry and partner, build both new codes.
   always_comb begin
      a_val = va_ff ? rd_a_ff : '0;
      b_val = vb_ff ? rd_b_ff : '0;
      if (a_val.len == '0) begin
         fresh_idx = first_ff;
         part_idx  = second_ff;
         pval      = b_val;
      end else begin
         fresh_idx = second_ff;
         part_idx  = first_ff;
         pval      = a_val;
      end
      fresh_app = append_bit(pval, 1'b1);
      part_app  = append_bit((fresh_idx == part_idx) ? fresh_app.entry : pval, 1'b0);
   end

   // Pixel: join pending bits with the code and cut out up to two bytes.
   always_comb begin
      len_c     = (a_val.len > 5'd16) ? 5'd16 : a_val.len;
      code_mask = 16'hFFFF >> (5'd16 - len_c);
      total     = ({acc_ff, 16'd0} >> (5'd16 - len_c)) | {7'd0, a_val.bits & code_mask};
      nbits     = {2'd0, pend_ff} + len_c;
      sh1       = total >> (nbits - 5'd8);
      sh2       = total >> (nbits - 5'd16);
      cnt1      = sat_inc(emitted_ff);
      cnt2      = sat_inc(cnt1);
   end

   // Sequencer, packer state and queue pushes
   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      pend_in    = pend_ff;
      emitted_in = emitted_ff;
      ovf_in     = ovf_ff;
      partner_in = partner_ff;
      pnew_in    = pnew_ff;
      wr_en      = 1'b0;
      wr_addr    = fresh_idx;
      wr_data    = fresh_app.entry;
      push_n     = 2'd0;
      push0      = '0;
      push1      = '0;
      need       = 2'd0;
      room       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (kind_ff)
               REQ_MERGE: begin
                  wr_en      = 1'b1;
                  ovf_in     = ovf_ff | fresh_app.ovf | part_app.ovf;
                  partner_in = part_idx;
                  pnew_in    = part_app.entry;
                  state_in   = ST_WR2;
               end
               REQ_PIXEL: begin
                  need = (nbits >= 5'd16) ? 2'd2 : ((nbits >= 5'd8) ? 2'd1 : 2'd0);
                  room = ({1'b0, q_cnt_ff} + {1'b0, need}) <= 3'd2;
                  if (room) begin
                     push_n = need;
                     push0  = '{data_byte: sh1[7:0], last: 1'b0, count: cnt1, ovf: ovf_ff};
                     push1  = '{data_byte: sh2[7:0], last: 1'b0, count: cnt2, ovf: ovf_ff};
                     if (need == 2'd2) begin
                        emitted_in = cnt2;
                     end else if (need == 2'd1) begin
                        emitted_in = cnt1;
                     end
                     acc_in   = total[6:0] & (7'h7F >> (3'd7 - nbits[2:0]));
                     pend_in  = nbits[2:0];
                     state_in = ST_IDLE;
                  end
               end
               REQ_FLUSH: begin
                  if (pend_ff == 3'd0) begin
                     state_in = ST_IDLE;
                  end else if (q_cnt_ff != 2'd2) begin
                     push_n     = 2'd1;
                     push0      = '{data_byte: 8'({acc_ff, 1'b0} << (3'd7 - pend_ff)),
                                    last: 1'b1, count: cnt1, ovf: ovf_ff};
                     emitted_in = cnt1;
                     acc_in     = '0;
                     pend_in    = '0;
                     state_in   = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_WR2: begin
            wr_en    = 1'b1;
            wr_addr  = partner_ff;
            wr_data  = pnew_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_ff     <= '0;
         pend_ff    <= '0;
         emitted_ff <= '0;
         ovf_ff     <= 1'b0;
         q_wr_ff    <= 1'b0;
         q_rd_ff    <= 1'b0;
         q_cnt_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         pend_ff    <= pend_in;
         emitted_ff <= emitted_in;
         ovf_ff     <= ovf_in;
         q_wr_ff    <= q_wr_ff ^ push_n[0];
         q_rd_ff    <= q_rd_ff ^ pop;
         q_cnt_ff   <= q_cnt_ff + push_n - {1'b0, pop};
      end
   end

   // Payload registers: captured item, partner write and queue slots
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff   <= req_tuser;
         first_ff  <= req_tdata[7:0];
         second_ff <= req_tdata[15:8];
      end
      partner_ff <= partner_in;
      pnew_ff    <= pnew_in;
      if (push_n != 2'd0) begin
         q_mem_ff[q_wr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         q_mem_ff[~q_wr_ff] <= push1;
      end
   end

endmodule

FILE: test/huffman_table_build_and_pack_top_test.sv
// Self-checking stream testbench for the Huffman code table builder and bit packer.
`timescale 1ns / 1ps

module huffman_table_build_and_pack_top_test;
   import hufftbp_pkg::*;

   // Request kind that the block ignores
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CALM_ITEMS = 400;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

   // One packed output byte with its side fields
   typedef struct packed {
      logic [7:0]         data_byte;
      logic               last;
      logic [COUNT_W-1:0] count;
      logic               ovf;
   } coded_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = REQ_MERGE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   // Mirror of the block's state
   logic [LEN_W-1:0]   code_len_mirror [SYMBOLS];
   logic [CODE_W-1:0]  code_bits_mirror [SYMBOLS];
   logic [7:0]         packer_acc;
   logic [2:0]         packer_pending;
   logic [COUNT_W-1:0] bytes_emitted;
   logic               overflow_flag;
   coded_byte_type     awaited_bytes[$];

   // Run control and bookkeeping
   logic calm_mode = 1'b0;
   logic rsp_hold_request = 1'b0;
   int   error_count = 0;
   int   bytes_checked = 0;
   int   items_accepted = 0;
   int   hold_stretches = 0;
   int   kind_count[4] = '{0, 0, 0, 0};

   huffman_table_build_and_pack_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Generous bound on the whole run.
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void record_failure(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, what);
      end
   endfunction

   // Append one bit to a mirrored code; a code at the cap drops it and raises overflow.
   function automatic void extend_code(input int idx, input logic b);
      if (code_len_mirror[idx] >= LEN_W'(LEN_CAP)) begin
         overflow_flag = 1'b1;
      end else begin
         code_bits_mirror[idx] = {code_bits_mirror[idx][CODE_W-2:0], b};
         code_len_mirror[idx]  = code_len_mirror[idx] + LEN_W'(1);
      end
   endfunction

   // Count one output byte and queue it for the checker.
   function automatic void queue_byte(input logic [7:0] value, input logic last);
      coded_byte_type cb;
      if (bytes_emitted != COUNT_TOP) begin
         bytes_emitted = bytes_emitted + COUNT_W'(1);
      end
      cb.data_byte = value;
      cb.last      = last;
      cb.count     = bytes_emitted;
      cb.ovf       = overflow_flag;
      awaited_bytes.push_back(cb);
   endfunction

   // Work out the bytes that one accepted beat causes and update the mirror.
   function automatic void apply_item(input logic [1:0] kind, input logic [7:0] first,
                                      input logic [7:0] second, input logic [7:0] pixel);
      int          fresh;
      int          partner;
      int          len;
      int          nbits;
      int          emitted;
      logic [23:0] total;
      case (kind)
         REQ_MERGE: begin
            // An empty first entry is the fresh one; otherwise the second is overwritten.
            if (code_len_mirror[first] == '0) begin
               fresh   = first;
               partner = second;
            end else begin
               fresh   = second;
               partner = first;
            end
            code_len_mirror[fresh]  = code_len_mirror[partner];
            code_bits_mirror[fresh] = code_bits_mirror[partner];
            extend_code(fresh, 1'b1);
            extend_code(partner, 1'b0);
         end
         REQ_PIXEL: begin
            len   = code_len_mirror[pixel];
            total = (24'(packer_acc) << len) |
                    (24'(code_bits_mirror[pixel]) & ((24'd1 << len) - 24'd1));
            nbits   = int'(packer_pending) + len;
            emitted = 0;
            while (nbits >= 8 && emitted < 2) begin
               queue_byte(8'(total >> (nbits - 8)), 1'b0);
               nbits -= 8;
               emitted++;
            end
            packer_acc     = 8'(total & ((24'd1 << nbits) - 24'd1));
            packer_pending = 3'(nbits);
         end
         REQ_FLUSH: begin
            // Only a partial byte is padded out; an empty packer gives nothing.
            if (packer_pending != '0) begin
               queue_byte(8'(packer_acc << (8 - int'(packer_pending))), 1'b1);
               packer_acc     = '0;
               packer_pending = '0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Offer one beat on req_ and predict its bytes once it is taken.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] first,
                            input logic [7:0] second, input logic [7:0] pixel);
      int gap;
      if (!calm_mode && $urandom_range(99) < 6) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {pixel, second, first};
      do @(posedge clock); while (!req_tready);
      apply_item(kind, first, second, pixel);
      kind_count[kind]++;
      if (kind != REQ_UNUSED) begin
         items_accepted++;
      end
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_merge(input logic [7:0] first, input logic [7:0] second);
      send_item(REQ_MERGE, first, second, 8'($urandom));
   endtask

   task automatic send_pixel(input logic [7:0] pixel);
      send_item(REQ_PIXEL, 8'($urandom), 8'($urandom), pixel);
   endtask

   task automatic send_flush();
      send_item(REQ_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Empty code, flush with nothing pending and the unused kind: no bytes at all.
   task automatic test_empty_table();
      send_pixel(8'h80);
      send_flush();
      send_item(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      stop_sending();
   endtask

   // Hand-built codes giving all-ones, all-zeros, padded and self-merged patterns.
   task automatic test_directed_codes();
      send_merge(8'h00, 8'hFF);
      send_merge(8'h00, 8'h03);
      send_merge(8'h03, 8'h04);
      send_merge(8'h04, 8'h05);
      send_pixel(8'h05);
      send_pixel(8'h05);
      send_merge(8'hFF, 8'h06);
      send_merge(8'hFF, 8'h07);
      send_merge(8'hFF, 8'h08);
      send_pixel(8'hFF);
      send_pixel(8'hFF);
      send_pixel(8'h03);
      send_flush();
      send_pixel(8'h08);
      send_pixel(8'h07);
      send_pixel(8'h06);
      send_flush();
      // Same symbol on both sides of a pair.
      send_merge(8'h09, 8'h09);
      repeat (4) send_pixel(8'h09);
      // Ends on a whole byte, so this flush gives nothing.
      send_flush();
      stop_sending();
   endtask

   // Mostly small trees built root first, then pixels over their leaves; some noise.
   task automatic test_random_streams();
      logic [7:0] leaves[$];
      logic [7:0] sym;
      int         start;
      int         leaf_count;
      int         pixel_count;
      int         i;
      start = items_accepted;
      while (items_accepted < start + RANDOM_ITEMS) begin
         calm_mode = (items_accepted - start) < CALM_ITEMS;
         if ($urandom_range(99) < 85) begin
            leaves.delete();
            leaf_count = $urandom_range(2, 10);
            leaves.push_back(8'($urandom));
            leaves.push_back(8'($urandom));
            send_merge(leaves[0], leaves[1]);
            for (i = 2; i < leaf_count; i++) begin
               sym = 8'($urandom);
               send_merge(leaves[$urandom_range(leaves.size() - 1)], sym);
               leaves.push_back(sym);
            end
            pixel_count = $urandom_range(8, 60);
            for (i = 0; i < pixel_count; i++) begin
               if ($urandom_range(9) == 0) begin
                  send_pixel(8'($urandom));
               end else begin
                  send_pixel(leaves[$urandom_range(leaves.size() - 1)]);
               end
            end
            if ($urandom_range(3) != 0) begin
               send_flush();
            end
         end else begin
            pixel_count = $urandom_range(1, 8);
            for (i = 0; i < pixel_count; i++) begin
               send_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
         end
      end
      calm_mode = 1'b0;
      stop_sending();
   endtask

   // Self-merges push one code past the cap; pixels of that code then give two bytes each.
   task automatic test_code_length_limit();
      repeat (9) send_merge(8'h40, 8'h40);
      send_pixel(8'h40);
      send_pixel(8'h03);
      send_pixel(8'h40);
      send_pixel(8'h40);
      send_flush();
      stop_sending();
   endtask

   // The receiver holds off while long codes keep coming, so the input stalls.
   task automatic test_output_backpressure();
      int i;
      rsp_hold_request = 1'b1;
      for (i = 0; i < 40; i++) begin
         send_pixel(($urandom_range(3) == 0) ? 8'($urandom) : 8'h40);
      end
      send_flush();
      stop_sending();
   endtask

   // Receiver ready: random stalls, none in calm stretches, one long hold on request.
   initial begin : rsp_ready_driver
      int held;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            hold_stretches++;
         end
         rsp_tready <= calm_mode || ($urandom_range(99) >= 6);
      end
   end

   // Compare each result beat with the oldest predicted byte.
   always @(posedge clock) begin : result_checker
      coded_byte_type want;
      coded_byte_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.data_byte = rsp_tdata[7:0];
         seen.last      = rsp_tlast;
         seen.count     = rsp_tdata[31:8];
         seen.ovf       = rsp_tdata[32];
         bytes_checked++;
         if (awaited_bytes.size() == 0) begin
            record_failure($sformatf("unexpected beat: byte %02h last %0b count %0d ovf %0b",
                                     seen.data_byte, seen.last, seen.count, seen.ovf));
         end else begin
            want = awaited_bytes.pop_front();
            if (seen.data_byte !== want.data_byte || seen.last !== want.last ||
                seen.count !== want.count || seen.ovf !== want.ovf) begin
               record_failure($sformatf(
                  "mismatch: expected byte %02h last %0b count %0d ovf %0b, got %02h %0b %0d %0b",
                  want.data_byte, want.last, want.count, want.ovf,
                  seen.data_byte, seen.last, seen.count, seen.ovf));
            end
         end
      end
   end

   initial begin
      for (int s = 0; s < SYMBOLS; s++) begin
         code_len_mirror[s]  = '0;
         code_bits_mirror[s] = '0;
      end
      packer_acc     = '0;
      packer_pending = '0;
      bytes_emitted  = '0;
      overflow_flag  = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_directed_codes();
      test_random_streams();
      test_code_length_limit();
      test_output_backpressure();

      // Let every predicted byte arrive, then watch for strays.
      while (awaited_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d merges, %0d pixels, %0d flushes and %0d ignored beats;",
               kind_count[REQ_MERGE], kind_count[REQ_PIXEL], kind_count[REQ_FLUSH],
               kind_count[REQ_UNUSED]);
      $display("%0d bytes checked, long receiver holds: %0d, code length overflow %s.",
               bytes_checked, hold_stretches,
               overflow_flag ? "was reached" : "was never reached");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
